>>> sv/ppc_pkg.sv
package ppc_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 16;

	localparam int COORD_W = 32;
	localparam int DIST_W  = 34;
	localparam int ACC_W   = 50;
	localparam int TOL_W   = 31;
	localparam int CNT_W   = 5;
	localparam int STAT_W  = 3;
	localparam int QUO_W   = 64;
	localparam int DEN_W   = 34;
	localparam int FRAC_SH = 30;

	localparam logic signed [ACC_W-1:0] DIST_MAX_A = 50'sd8589934591;
	localparam logic signed [ACC_W-1:0] DIST_MIN_A = -50'sd8589934592;

	// configuration register indexes
	localparam logic [2:0] REG_NORMAL_X  = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
	localparam logic [2:0] REG_OFFSET    = 3'd3;
	localparam logic [2:0] REG_TOLERANCE = 3'd4;

	// polygon status codes
	localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
	localparam logic [STAT_W-1:0] ST_FEW_INPUTS  = 3'd1;
	localparam logic [STAT_W-1:0] ST_FEW_OUTPUTS = 3'd2;
	localparam logic [STAT_W-1:0] ST_CAPACITY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_ISECT       = 3'd4;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic                      last_vertex;
	} vtx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      vertex_valid;
		logic                      end_of_polygon;
		logic [STAT_W-1:0]         clip_status;
		logic [CNT_W-1:0]          emitted_count;
	} res_t;

	typedef struct packed {
		logic       load;
		logic       mul_dist;
		logic       acc;
		logic       dist_load;
		logic       advance;
		logic       edge_sel;
		logic [1:0] axis;
		logic       div_start;
		logic       lmul_hi;
		logic       lacc;
		logic       store_axis;
		logic       push_a;
		logic       push_i;
		logic       err_cap;
		logic       err_isect;
		logic       flush;
		logic       final_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic first_input;
		logic last;
		logic sticky_nz;
		logic ain;
		logic bin;
		logic denom_zero;
		logic tally_full;
		logic lerp_ovf;
		logic push_ok;
		logic out_free;
		logic hold_valid;
		logic div_done;
	} ctl_sts_t;

endpackage

>>> sv/polygon_plane_clipper.sv
// Channel  Dir  Handshake            Payload
// vtx      in   vtx_valid/vtx_stall  ppc_pkg::vtx_t, one polygon vertex
// res      out  res_valid/res_stall  ppc_pkg::res_t, clipped vertex or status
// cfg      in   cfg_valid/cfg_ready  cfg_index (register), cfg_data
//
// One vertex at a time; each edge that crosses the plane adds work in the radix-2
// divider that forms the intersection fraction and in the shared multiplier.
// Reset clears the plane registers to a z-up plane and all per-polygon state.
// A stalled result holds in the output register; a new vertex waits on it
// only when a further result has to be pushed out behind it.
module polygon_plane_clipper #(
	parameter int unsigned MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vtx_valid,
	output logic          vtx_stall,
	input  ppc_pkg::vtx_t vtx,
	output logic          res_valid,
	input  logic          res_stall,
	output ppc_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import ppc_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// configuration is taken in any cycle; software must write it only while idle, which the block leaves to the user
	assign cfg_ready = 1'b1;

	// sequencer: distance, edge walk, divide, interpolate, push and flush
	ppc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: plane registers, vertex state, multiplier, divider, result registers
	ppc_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

`ifndef SYNTH
	// a vertex transaction blocks the input until its work is done
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && !vtx_stall |=> vtx_stall)
		else $error("second vertex accepted while one is in work");

	// a status code only travels on the closing result of a polygon
	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.end_of_polygon |-> res.clip_status == ST_OK)
		else $error("status on a non-final result");

	// a result without a vertex is only the closing status
	a_bare_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.vertex_valid |-> res.end_of_polygon)
		else $error("empty result that does not end a polygon");

	// the emitted count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(res.emitted_count) <= MAX_VERTICES)
		else $error("emitted count beyond capacity");
`endif
endmodule

>>> sv/ppc_div.sv
module ppc_div #(
	parameter int NUM_W = ppc_pkg::QUO_W,
	parameter int DEN_W = ppc_pkg::DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

>>> sv/ppc_dp.sv
module ppc_dp #(
	parameter int unsigned MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ppc_pkg::vtx_t      vtx,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  ppc_pkg::ctl_cmd_t  cmd,
	output ppc_pkg::ctl_sts_t  sts,
	output ppc_pkg::res_t      res,
	output logic               res_valid,
	input  logic               res_stall
);
	import ppc_pkg::*;

	localparam int TALLY_W  = $clog2(MAX_VERTICES + 1);
	localparam int TALLY_XW = TALLY_W + CNT_W;

	// configuration
	logic signed [COORD_W-1:0] nrm_x_q, nrm_y_q, nrm_z_q, offset_q;
	logic [TOL_W-1:0]          tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_x_q  <= '0;
			nrm_y_q  <= '0;
			nrm_z_q  <= 32'sd65536;
			offset_q <= '0;
			tol_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORMAL_X:  nrm_x_q  <= cfg_data;
				REG_NORMAL_Y:  nrm_y_q  <= cfg_data;
				REG_NORMAL_Z:  nrm_z_q  <= cfg_data;
				REG_OFFSET:    offset_q <= cfg_data;
				REG_TOLERANCE: tol_q    <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// vertex registers
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, cur_z_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, first_z_q;
	logic signed [COORD_W-1:0] ix_q, iy_q, iz_q;
	logic signed [COORD_W-1:0] hold_x_q, hold_y_q, hold_z_q;
	logic signed [DIST_W-1:0]  cur_d_q, prev_d_q, first_d_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [65:0]        prod_q;
	logic [63:0]               plo_q;
	logic [95:0]               sum_q;
	logic                      qneg_q;
	logic                      last_q;
	logic                      hold_valid_q;
	logic [1:0]                seen_q;
	logic [TALLY_W-1:0]        tally_q;
	logic [STAT_W-1:0]         sticky_q;
	res_t                      res_q;
	logic                      res_valid_q;

	// shared multiplier operands
	logic signed [COORD_W-1:0] cur_ax, nrm_ax, a_ax, b_ax;
	logic signed [32:0]        mul_a, mul_b;
	logic [QUO_W-1:0]          quo;
	logic                      div_busy;

	// edge operands
	logic signed [COORD_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
	logic signed [DIST_W-1:0]  a_d, b_d, dist_sat;
	logic signed [DIST_W:0]    denom, neg_tol;
	logic [DIST_W-1:0]         amag, dmag;
	logic signed [32:0]        diff;
	logic [31:0]               ud;
	logic                      dneg;

	// interpolation check
	logic [63:0]         sh;
	logic signed [34:0]  lerp_r;
	logic                lerp_ovf;

	logic                out_free;
	logic [TALLY_XW-1:0] tally_x;
	logic [CNT_W-1:0]    cnt_sat;
	logic [STAT_W-1:0]   status;

	always_comb begin
		case (cmd.axis)
			AX_X: begin cur_ax = cur_x_q; nrm_ax = nrm_x_q; a_ax = a_x; b_ax = b_x; end
			AX_Y: begin cur_ax = cur_y_q; nrm_ax = nrm_y_q; a_ax = a_y; b_ax = b_y; end
			default: begin cur_ax = cur_z_q; nrm_ax = nrm_z_q; a_ax = a_z; b_ax = b_z; end
		endcase
	end

	assign a_x = cmd.edge_sel ? cur_x_q : prev_x_q;
	assign a_y = cmd.edge_sel ? cur_y_q : prev_y_q;
	assign a_z = cmd.edge_sel ? cur_z_q : prev_z_q;
	assign a_d = cmd.edge_sel ? cur_d_q : prev_d_q;
	assign b_x = cmd.edge_sel ? first_x_q : cur_x_q;
	assign b_y = cmd.edge_sel ? first_y_q : cur_y_q;
	assign b_z = cmd.edge_sel ? first_z_q : cur_z_q;
	assign b_d = cmd.edge_sel ? first_d_q : cur_d_q;

	assign neg_tol = -$signed({4'b0, tol_q});
	assign denom   = $signed({a_d[DIST_W-1], a_d}) - $signed({b_d[DIST_W-1], b_d});
	assign amag    = a_d[DIST_W-1] ? DIST_W'(-a_d) : a_d;
	assign dmag    = denom[DIST_W] ? DIST_W'(-denom) : denom[DIST_W-1:0];

	assign diff = $signed({b_ax[31], b_ax}) - $signed({a_ax[31], a_ax});
	assign dneg = diff[32];
	assign ud   = dneg ? 32'(-diff) : diff[31:0];

	always_comb begin
		if (cmd.mul_dist) begin
			mul_a = {cur_ax[31], cur_ax};
			mul_b = {nrm_ax[31], nrm_ax};
		end else begin
			mul_a = {1'b0, cmd.lmul_hi ? quo[63:32] : quo[31:0]};
			mul_b = {1'b0, ud};
		end
	end

	assign dist_sat = (acc_q > DIST_MAX_A) ? DIST_MAX_A[DIST_W-1:0] :
	                  (acc_q < DIST_MIN_A) ? DIST_MIN_A[DIST_W-1:0] : acc_q[DIST_W-1:0];

	assign sh     = sum_q[93:30];
	assign lerp_r = (qneg_q != dneg) ? $signed({{3{a_ax[31]}}, a_ax}) - $signed({1'b0, sh[33:0]})
	                                 : $signed({{3{a_ax[31]}}, a_ax}) + $signed({1'b0, sh[33:0]});
	assign lerp_ovf = (sum_q[95:94] != 2'b00) || (sh > 64'h2_0000_0000) ||
	                  (lerp_r[34:31] != {4{lerp_r[31]}});

	assign out_free = !res_valid_q || !res_stall;
	assign tally_x  = TALLY_XW'(tally_q);
	assign cnt_sat  = (tally_x > TALLY_XW'(31)) ? CNT_W'(31) : tally_x[CNT_W-1:0];

	always_comb begin
		if (seen_q < 2'd3)                    status = ST_FEW_INPUTS;
		else if (sticky_q != ST_OK)           status = sticky_q;
		else if (tally_q < TALLY_W'(3))       status = ST_FEW_OUTPUTS;
		else                                  status = ST_OK;
	end

	ppc_div #(.NUM_W(QUO_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({amag, {FRAC_SH{1'b0}}}),
		.den    (dmag),
		.busy   (div_busy),
		.quo    (quo)
	);

	// arithmetic pipeline registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			cur_x_q <= vtx.coord_x;
			cur_y_q <= vtx.coord_y;
			cur_z_q <= vtx.coord_z;
			acc_q   <= -ACC_W'(offset_q);
		end
		if (cmd.acc)        acc_q   <= acc_q + $signed(prod_q[65:16]);
		if (cmd.dist_load)  cur_d_q <= dist_sat;
		if (cmd.div_start)  qneg_q  <= a_d[DIST_W-1] != denom[DIST_W];
		if (cmd.lmul_hi)    plo_q   <= prod_q[63:0];
		if (cmd.lacc)       sum_q   <= {32'b0, plo_q} + {prod_q[63:0], 32'b0};
		if (cmd.store_axis) begin
			case (cmd.axis)
				AX_X:    ix_q <= lerp_r[31:0];
				AX_Y:    iy_q <= lerp_r[31:0];
				default: iz_q <= lerp_r[31:0];
			endcase
		end
		if (cmd.advance) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			prev_z_q <= cur_z_q;
			prev_d_q <= cur_d_q;
			if (seen_q == 2'd0) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
				first_z_q <= cur_z_q;
				first_d_q <= cur_d_q;
			end
		end
		if (cmd.push_a) begin
			hold_x_q <= a_x;
			hold_y_q <= a_y;
			hold_z_q <= a_z;
		end
		if (cmd.push_i) begin
			hold_x_q <= ix_q;
			hold_y_q <= iy_q;
			hold_z_q <= iz_q;
		end
		// old held vertex moves out on a push or a flush; its count is the tally before this push
		if ((cmd.push_a || cmd.push_i) && hold_valid_q || cmd.flush) begin
			res_q <= '{hold_x_q, hold_y_q, hold_z_q, 1'b1, 1'b0, ST_OK, cnt_sat};
		end
		if (cmd.final_out) begin
			if (hold_valid_q) res_q <= '{hold_x_q, hold_y_q, hold_z_q, 1'b1, 1'b1, status, cnt_sat};
			else              res_q <= '{'0, '0, '0, 1'b0, 1'b1, status, cnt_sat};
		end
	end

	// per-polygon control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			seen_q       <= '0;
			tally_q      <= '0;
			sticky_q     <= ST_OK;
			res_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) last_q <= vtx.last_vertex;
			if (cmd.advance && seen_q != 2'd3) seen_q <= seen_q + 2'd1;
			if (cmd.err_cap)   sticky_q <= ST_CAPACITY;
			if (cmd.err_isect) sticky_q <= ST_ISECT;
			if (cmd.push_a || cmd.push_i) begin
				hold_valid_q <= 1'b1;
				tally_q      <= tally_q + 1'b1;
			end
			if (cmd.flush) hold_valid_q <= 1'b0;
			if (cmd.final_out) begin
				hold_valid_q <= 1'b0;
				seen_q       <= '0;
				tally_q      <= '0;
				sticky_q     <= ST_OK;
			end
			if ((cmd.push_a || cmd.push_i) && hold_valid_q || cmd.flush || cmd.final_out)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	assign sts.first_input = seen_q == 2'd0;
	assign sts.last        = last_q;
	assign sts.sticky_nz   = sticky_q != ST_OK;
	assign sts.ain         = $signed({a_d[DIST_W-1], a_d}) >= neg_tol;
	assign sts.bin         = $signed({b_d[DIST_W-1], b_d}) >= neg_tol;
	assign sts.denom_zero  = denom == '0;
	assign sts.tally_full  = tally_q >= TALLY_W'(MAX_VERTICES);
	assign sts.lerp_ovf    = lerp_ovf;
	assign sts.push_ok     = !hold_valid_q || out_free;
	assign sts.out_free    = out_free;
	assign sts.hold_valid  = hold_valid_q;
	assign sts.div_done    = !div_busy;

	assign res       = res_q;
	assign res_valid = res_valid_q;
endmodule

>>> sv/ppc_ctrl.sv
module ppc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	output logic              vtx_stall,
	input  ppc_pkg::ctl_sts_t sts,
	output ppc_pkg::ctl_cmd_t cmd
);
	import ppc_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_MUL   = 16'h0002,
		S_ACC   = 16'h0004,
		S_DIST  = 16'h0008,
		S_STEP  = 16'h0010,
		S_EDGE  = 16'h0020,
		S_PUSHA = 16'h0040,
		S_DIV   = 16'h0080,
		S_LMLO  = 16'h0100,
		S_LMHI  = 16'h0200,
		S_LACC  = 16'h0400,
		S_LFIN  = 16'h0800,
		S_ICAP  = 16'h1000,
		S_PUSHI = 16'h2000,
		S_EDONE = 16'h4000,
		S_FLUSH = 16'h8000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       edge_q, edge_d;
	logic       crossing;

	assign crossing = (sts.ain != sts.bin) && !sts.denom_zero;

	always_comb begin
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.edge_sel = edge_q;
		state_d      = state_q;
		axis_d       = axis_q;
		edge_d       = edge_q;
		case (state_q)
			S_IDLE: if (vtx_valid) begin
				cmd.load = 1'b1;
				axis_d   = AX_X;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul_dist = 1'b1;
				state_d      = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				if (axis_q == AX_Z) begin
					state_d = S_DIST;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_DIST: begin
				cmd.dist_load = 1'b1;
				edge_d        = 1'b0;
				state_d       = sts.first_input ? S_STEP : S_EDGE;
			end
			S_EDGE: begin
				if (sts.sticky_nz) begin
					state_d = S_EDONE;
				end else if (sts.ain) begin
					if (sts.tally_full) begin
						cmd.err_cap = 1'b1;
						state_d     = S_EDONE;
					end else begin
						state_d = S_PUSHA;
					end
				end else if (crossing) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_EDONE;
				end
			end
			S_PUSHA: if (sts.push_ok) begin
				cmd.push_a = 1'b1;
				if (crossing) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_EDONE;
				end
			end
			S_DIV: if (sts.div_done) begin
				axis_d  = AX_X;
				state_d = S_LMLO;
			end
			S_LMLO: begin
				state_d = S_LMHI;
			end
			S_LMHI: begin
				cmd.lmul_hi = 1'b1;
				state_d     = S_LACC;
			end
			S_LACC: begin
				cmd.lacc = 1'b1;
				state_d  = S_LFIN;
			end
			S_LFIN: begin
				if (sts.lerp_ovf) begin
					cmd.err_isect = 1'b1;
					state_d       = S_EDONE;
				end else begin
					cmd.store_axis = 1'b1;
					if (axis_q == AX_Z) begin
						state_d = S_ICAP;
					end else begin
						axis_d  = axis_q + 2'd1;
						state_d = S_LMLO;
					end
				end
			end
			S_ICAP: begin
				if (sts.tally_full) begin
					cmd.err_cap = 1'b1;
					state_d     = S_EDONE;
				end else begin
					state_d = S_PUSHI;
				end
			end
			S_PUSHI: if (sts.push_ok) begin
				cmd.push_i = 1'b1;
				state_d    = S_EDONE;
			end
			S_EDONE: state_d = edge_q ? S_FLUSH : S_STEP;
			S_STEP: begin
				cmd.advance = 1'b1;
				if (sts.last) begin
					edge_d  = 1'b1;
					state_d = S_EDGE;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (sts.last) begin
					if (sts.out_free) begin
						cmd.final_out = 1'b1;
						state_d       = S_IDLE;
					end
				end else if (!sts.hold_valid) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= AX_X;
			edge_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			edge_q  <= edge_d;
		end
	end

	assign vtx_stall = state_q != S_IDLE;
endmodule
